// ===== sv/mrtu_pkg.sv =====
`timescale 1ns / 1ps

package mrtu_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_COLLECT = 3'd0,
    ST_READY   = 3'd1,
    ST_CRCERR  = 3'd2,
    ST_UNSUP   = 3'd3,
    ST_EXIT    = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [8:0] held_count;
    logic [8:0] expected_length;
  } result_t;

  // supported function codes
  localparam logic [7:0] FN_READ_HOLD    = 8'h03;
  localparam logic [7:0] FN_READ_INPUT   = 8'h04;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

  localparam logic [7:0] ASCII_LF = 8'h0A;
  localparam logic [7:0] ASCII_CR = 8'h0D;

  localparam logic [8:0] FIXED_LEN      = 9'd8;
  localparam logic [8:0] MULTI_BASE_LEN = 9'd9;
  localparam logic [8:0] MULTI_CNT_POS  = 9'd6;
  localparam logic [8:0] FN_POS         = 9'd1;
  localparam logic [8:0] MAX_LEN        = 9'd264;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one byte through the reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic is_crlf(input logic [7:0] b);
    return (b == ASCII_CR) || (b == ASCII_LF);
  endfunction

endpackage

// ===== sv/modbus_rtu_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// modbus rtu request deframer
// in channel: one received byte per request (in_rx_byte, in_valid/in_ready)
// out channel: one result per byte: status, bytes held and confirmed frame length
//   status 0 collecting, 1 frame ready, 2 crc error, 3 unsupported function,
//   4 exit (cr/lf function after cr/lf first byte)
// held_count and expected_length read 0 on any request that ends the frame
// an accepted byte waits in the input register until the output register is free
// throughput: one byte per cycle while out_ready stays high; the input register,
//   frame logic and output register form a two stage pipe, with the crc byte
//   update, frame end check and length decode as the only logic between them
// an unread result holds in the output register while the input register still
//   takes one more byte; in_ready drops only once both are full
// reset: synchronous, active low; clears both stages, empties the frame and
//   loads the crc with 0xffff
module modbus_rtu_frame_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [8:0] out_held_count,
  output logic [8:0] out_expected_length
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              out_free;
  logic              go;
  mrtu_pkg::result_t res;

  // byte moves into the frame logic when the output register can take its result
  assign go = hold_valid && out_free;

  mrtu_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (go),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // frame state, crc and length decode
  mrtu_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .rx_byte (hold_byte),
    .res     (res)
  );

  mrtu_out_reg u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (go),
    .res                 (res),
    .free                (out_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_held_count      (out_held_count),
    .out_expected_length (out_expected_length)
  );

endmodule

// ===== sv/mrtu_in_reg.sv =====
`timescale 1ns / 1ps

module mrtu_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       acc;

  assign in_ready = !valid_r || take;
  assign acc      = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (acc) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byte_r <= in_rx_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

// ===== sv/mrtu_frame.sv =====
`timescale 1ns / 1ps

module mrtu_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [7:0]       rx_byte,
  output mrtu_pkg::result_t res
);

  logic [8:0]  idx_r,   idx_nxt;
  logic [8:0]  want_r,  want_nxt;
  logic [15:0] crc_r,   crc_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  fn_r,    fn_nxt;
  logic [8:0]  idx_inc;
  mrtu_pkg::status_t status;

  always_comb begin
    idx_inc   = idx_r + 9'd1;
    first_nxt = (idx_r == 9'd0) ? rx_byte : first_r;
    fn_nxt    = (idx_r == mrtu_pkg::FN_POS) ? rx_byte : fn_r;
    crc_nxt   = mrtu_pkg::crc_byte(crc_r, rx_byte);
    idx_nxt   = idx_inc;
    want_nxt  = want_r;
    status    = mrtu_pkg::ST_COLLECT;

    if (want_r != 9'd0) begin
      // length known: end of frame check
      if (idx_inc >= want_r) begin
        status = (crc_nxt == 16'h0000) ? mrtu_pkg::ST_READY : mrtu_pkg::ST_CRCERR;
      end
    end else if (idx_inc >= 9'd2) begin
      unique case (fn_nxt) inside
        mrtu_pkg::FN_READ_HOLD, mrtu_pkg::FN_READ_INPUT, mrtu_pkg::FN_WRITE_SINGLE: begin
          want_nxt = mrtu_pkg::FIXED_LEN;
        end
        mrtu_pkg::FN_WRITE_MULTI: begin
          // byte count sits at offset 6, which is the byte in hand right now
          if (idx_r == mrtu_pkg::MULTI_CNT_POS) begin
            want_nxt = mrtu_pkg::MULTI_BASE_LEN + {1'b0, rx_byte};
          end
        end
        mrtu_pkg::ASCII_CR, mrtu_pkg::ASCII_LF: begin
          status = mrtu_pkg::is_crlf(first_nxt) ? mrtu_pkg::ST_EXIT : mrtu_pkg::ST_UNSUP;
        end
        default: begin
          status = mrtu_pkg::ST_UNSUP;
        end
      endcase
    end

    // any terminal status drops the frame
    if (status != mrtu_pkg::ST_COLLECT) begin
      idx_nxt   = 9'd0;
      want_nxt  = 9'd0;
      crc_nxt   = mrtu_pkg::CRC_INIT;
      first_nxt = 8'h00;
      fn_nxt    = 8'h00;
    end

    res.status          = status;
    res.held_count      = idx_nxt;
    res.expected_length = want_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 9'd0;
      want_r  <= 9'd0;
      crc_r   <= mrtu_pkg::CRC_INIT;
      first_r <= 8'h00;
      fn_r    <= 8'h00;
    end else if (go) begin
      idx_r   <= idx_nxt;
      want_r  <= want_nxt;
      crc_r   <= crc_nxt;
      first_r <= first_nxt;
      fn_r    <= fn_nxt;
    end
  end

  a_want_after_fn: assert property (@(posedge clk) disable iff (!rst_n)
    (want_r != 9'd0) |-> (idx_r >= 9'd2))
    else $error("length known before function byte");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= mrtu_pkg::MAX_LEN)
    else $error("frame index past longest frame");

  a_want_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (want_r == 9'd0) || (want_r == mrtu_pkg::FIXED_LEN) ||
    ((want_r >= mrtu_pkg::MULTI_BASE_LEN) && (want_r <= mrtu_pkg::MAX_LEN)))
    else $error("illegal frame length");

  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (res.status != mrtu_pkg::ST_COLLECT)) |=>
      ((idx_r == 9'd0) && (crc_r == mrtu_pkg::CRC_INIT)))
    else $error("frame state not cleared after terminal status");

endmodule

// ===== sv/mrtu_out_reg.sv =====
`timescale 1ns / 1ps

module mrtu_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mrtu_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [8:0]        out_held_count,
  output logic [8:0]        out_expected_length
);

  logic              valid_r;
  logic              valid_nxt;
  mrtu_pkg::result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid           = valid_r;
  assign out_status          = 3'(res_r.status);
  assign out_held_count      = res_r.held_count;
  assign out_expected_length = res_r.expected_length;

endmodule

// ===== verif/modbus_rtu_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps

// byte-level check of the modbus rtu deframer: every received byte gets one result
// (status, bytes held, confirmed length), predicted here and matched in order
module modbus_rtu_frame_receiver_top_tb;

  localparam int N_REQUESTS = 1050;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_TAIL = 120;   // last requests go through with no idling
  localparam int STORE_DEPTH = 512;

  typedef struct {
    logic [7:0] data;
    bit         hold;   // wait for every outstanding result before this request
  } rx_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [8:0] out_held_count;
  logic [8:0] out_expected_length;

  modbus_rtu_frame_receiver_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_held_count      (out_held_count),
    .out_expected_length (out_expected_length)
  );

  always #2 clk = ~clk;

  // requests waiting to be sent and results waiting to arrive
  rx_req_t rx_q[$];
  mrtu_pkg::result_t pending_results[$];

  int  cycles = 0;
  int  errors = 0;
  int  accepted = 0;
  int  n_ready = 0;
  int  n_crcerr = 0;
  int  n_unsup = 0;
  int  n_exit = 0;
  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  in_fire = 1'b0;
  bit  hold_next = 1'b0;

  // deframer state as the block should hold it
  logic [7:0]  frame_bytes [0:STORE_DEPTH-1];
  logic [8:0]  acc_idx = '0;
  logic [8:0]  acc_len = '0;
  logic [15:0] crc_acc = 16'hFFFF;
  logic [7:0]  acc_first = '0;
  logic [7:0]  acc_func = '0;

  // reflected crc-16, polynomial 0xa001, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit line_end(input logic [7:0] b);
    return (b == mrtu_pkg::ASCII_CR) || (b == mrtu_pkg::ASCII_LF);
  endfunction

  task automatic clear_frame();
    acc_idx = '0;
    acc_len = '0;
    crc_acc = 16'hFFFF;
    acc_first = '0;
    acc_func = '0;
  endtask

  // one received byte in, the result it should cause out
  task automatic deframe_byte(input logic [7:0] b, output mrtu_pkg::result_t r);
    mrtu_pkg::status_t st;
    st = mrtu_pkg::ST_COLLECT;
    frame_bytes[acc_idx] = b;
    if (acc_idx == 9'd0) begin
      acc_first = b;
    end else if (acc_idx == 9'd1) begin
      acc_func = b;
    end
    acc_idx = acc_idx + 9'd1;
    crc_acc = crc16_step(crc_acc, b);
    if (acc_len != 9'd0) begin
      // length known: the last byte closes the frame
      if (acc_idx >= acc_len) begin
        st = (crc_acc == 16'h0000) ? mrtu_pkg::ST_READY : mrtu_pkg::ST_CRCERR;
        clear_frame();
      end
    end else if (acc_idx >= 9'd2) begin
      case (acc_func) inside
        mrtu_pkg::FN_READ_HOLD, mrtu_pkg::FN_READ_INPUT, mrtu_pkg::FN_WRITE_SINGLE: begin
          acc_len = mrtu_pkg::FIXED_LEN;
        end
        mrtu_pkg::FN_WRITE_MULTI: begin
          // byte count at offset 6 decides the length
          if (acc_idx >= 9'd7) begin
            acc_len = mrtu_pkg::MULTI_BASE_LEN + {1'b0, frame_bytes[6]};
          end
        end
        mrtu_pkg::ASCII_LF, mrtu_pkg::ASCII_CR: begin
          st = line_end(acc_first) ? mrtu_pkg::ST_EXIT : mrtu_pkg::ST_UNSUP;
          clear_frame();
        end
        default: begin
          st = mrtu_pkg::ST_UNSUP;
          clear_frame();
        end
      endcase
    end
    r.status = st;
    r.held_count = acc_idx;
    r.expected_length = acc_len;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_req_t req;
    req.data = b;
    req.hold = hold_next;
    hold_next = 1'b0;
    rx_q.push_back(req);
  endtask

  // whole request frame with its crc, low byte first; bad flips one bit
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] fn, input int cnt,
                             input bit bad);
    logic [7:0]  body[$];
    logic [15:0] c;
    int          pos;
    body.push_back(addr);
    body.push_back(fn);
    repeat (4) body.push_back(8'($urandom_range(0, 255)));
    if (fn == mrtu_pkg::FN_WRITE_MULTI) begin
      body.push_back(8'(cnt));
      repeat (cnt) body.push_back(8'($urandom_range(0, 255)));
    end
    c = 16'hFFFF;
    foreach (body[i]) c = crc16_step(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (bad) begin
      pos = $urandom_range(0, 1) ? body.size() - 1 : $urandom_range(2, 5);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (body[i]) queue_byte(body[i]);
  endtask

  // stimulus: directed frames first, then a mostly well-formed random stream
  initial begin : stimulus
    int         pick;
    int         big_left;
    bit         mid_hold_done;
    logic [7:0] fn;
    logic [7:0] first;
    big_left = 3;
    mid_hold_done = 1'b0;

    // good read-holding frame from address 0
    queue_frame(8'h00, mrtu_pkg::FN_READ_HOLD, 0, 1'b0);
    // cr then lf: exit
    queue_byte(mrtu_pkg::ASCII_CR);
    queue_byte(mrtu_pkg::ASCII_LF);
    // lf then cr: exit
    queue_byte(mrtu_pkg::ASCII_LF);
    queue_byte(mrtu_pkg::ASCII_CR);
    // cr function after an ordinary first byte: unsupported
    queue_byte(8'h41);
    queue_byte(mrtu_pkg::ASCII_CR);
    // all-ones function code: unsupported
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    // shortest write-multiple frame, byte count 0
    queue_frame(8'hFF, mrtu_pkg::FN_WRITE_MULTI, 0, 1'b0);

    // pause the sender once the directed part is out
    hold_next = 1'b1;
    while (rx_q.size() < N_REQUESTS) begin
      if (rx_q.size() >= N_REQUESTS / 2 && !mid_hold_done) begin
        hold_next = 1'b1;
        mid_hold_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        case ($urandom_range(0, 3))
          0: fn = mrtu_pkg::FN_READ_HOLD;
          1: fn = mrtu_pkg::FN_READ_INPUT;
          2: fn = mrtu_pkg::FN_WRITE_SINGLE;
          default: fn = mrtu_pkg::FN_WRITE_MULTI;
        endcase
        // mostly short payloads, a few of the longest legal frame
        if (fn == mrtu_pkg::FN_WRITE_MULTI && big_left > 0 &&
            rx_q.size() + 300 < N_REQUESTS && $urandom_range(0, 99) < 4) begin
          big_left--;
          queue_frame(8'($urandom_range(0, 255)), fn, 255, $urandom_range(0, 99) < 15);
        end else begin
          queue_frame(8'($urandom_range(0, 255)), fn,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12),
                      $urandom_range(0, 99) < 15);
        end
      end else if (pick < 80) begin
        queue_byte($urandom_range(0, 1) ? mrtu_pkg::ASCII_CR : mrtu_pkg::ASCII_LF);
        queue_byte($urandom_range(0, 1) ? mrtu_pkg::ASCII_CR : mrtu_pkg::ASCII_LF);
      end else if (pick < 87) begin
        do first = 8'($urandom_range(0, 255)); while (line_end(first));
        queue_byte(first);
        queue_byte($urandom_range(0, 1) ? mrtu_pkg::ASCII_CR : mrtu_pkg::ASCII_LF);
      end else if (pick < 96) begin
        queue_byte(8'($urandom_range(0, 255)));
        do fn = 8'($urandom_range(0, 255));
        while (fn == mrtu_pkg::FN_READ_HOLD || fn == mrtu_pkg::FN_READ_INPUT ||
               fn == mrtu_pkg::FN_WRITE_SINGLE || fn == mrtu_pkg::FN_WRITE_MULTI ||
               line_end(fn));
        queue_byte(fn);
      end else begin
        // stray bytes that break the framing
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // everything sent, then everything answered, then a short drain
    wait (rx_q.size() == 0 && !in_valid);
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes: %0d frames ready, %0d crc errors, %0d unsupported, %0d exits",
             accepted, n_ready, n_crcerr, n_unsup, n_exit);
    if (errors == 0) begin
      $display("modbus_rtu_frame_receiver_top_tb OK");
    end else begin
      $display("modbus_rtu_frame_receiver_top_tb NOT OK");
    end
    $finish;
  end

  // cycle count, timeout and idling phases
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("modbus_rtu_frame_receiver_top_tb NOT OK");
      $finish;
    end
    // pick a new idling mix at regular points of the cycle count: none, light or heavy
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 10;
        default: in_idle_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 10;
        default: out_stall_pct = 35;
      endcase
    end
  end

  // request side: accepted bytes go through the predictor, results are checked
  always @(posedge clk) begin : monitor
    mrtu_pkg::result_t r;
    mrtu_pkg::result_t exp_r;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      deframe_byte(in_rx_byte, r);
      pending_results.push_back(r);
      accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          errors++;
        end
        if (out_held_count !== exp_r.held_count) begin
          $error("held_count: expected %0d, got %0d", exp_r.held_count, out_held_count);
          errors++;
        end
        if (out_expected_length !== exp_r.expected_length) begin
          $error("expected_length: expected %0d, got %0d",
                 exp_r.expected_length, out_expected_length);
          errors++;
        end
        case (exp_r.status)
          mrtu_pkg::ST_READY:  n_ready++;
          mrtu_pkg::ST_CRCERR: n_crcerr++;
          mrtu_pkg::ST_UNSUP:  n_unsup++;
          mrtu_pkg::ST_EXIT:   n_exit++;
          default: ;
        endcase
      end
    end
  end

  // sender: holds a byte until it is taken, then idles or presents the next one
  always @(negedge clk) begin : drive_in
    rx_req_t    req;
    logic       nv;
    logic [7:0] nb;
    if (rst_n && !(in_valid && !in_fire)) begin
      nv = 1'b0;
      nb = in_rx_byte;
      if (in_gap > 0) begin
        in_gap--;
      end else if (rx_q.size() > 0) begin
        if (rx_q[0].hold && pending_results.size() != 0) begin
          // wait for the block to drain completely
        end else if (rx_q.size() > QUIET_TAIL && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, 8) - 1;
        end else begin
          req = rx_q.pop_front();
          nv = 1'b1;
          nb = req.data;
        end
      end
      in_valid <= nv;
      in_rx_byte <= nb;
    end
  end

  // receiver: random stall bursts, none near the end
  always @(negedge clk) begin : drive_out
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (rx_q.size() > QUIET_TAIL && $urandom_range(0, 99) < out_stall_pct) begin
      out_gap = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

endmodule
